@@ design/bpc_pkg.sv @@
package bpc_pkg;

   localparam int TIME_WIDTH = 32;
   localparam int CFG_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET  = 16'd600;
   localparam logic [CFG_WIDTH-1:0] TOUCH_GUARD_RESET = 16'd50;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LONG_PRESS  = 1'b0,
      CSR_TOUCH_GUARD = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      EVT_NONE     = 3'd0,
      EVT_B1_SHORT = 3'd1,
      EVT_B1_LONG  = 3'd2,
      EVT_B2_SHORT = 3'd3,
      EVT_B2_LONG  = 3'd4,
      EVT_TOUCH    = 3'd5
   } event_code_type;

endpackage

@@ design/bpc_if.sv @@
interface bpc_req_if import bpc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [TIME_WIDTH-1:0] now_ms;
   logic                  button1_level;
   logic                  button2_level;
   logic                  touch_level;

   modport source (output valid, now_ms, button1_level, button2_level, touch_level,
                   input ready);
   modport sink   (input valid, now_ms, button1_level, button2_level, touch_level,
                   output ready);
endinterface

interface bpc_rsp_if import bpc_pkg::*; ();
   logic           valid;
   logic           ready;
   event_code_type event_code;

   modport source (output valid, event_code, input ready);
   modport sink   (input valid, event_code, output ready);
endinterface

interface bpc_csr_if import bpc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CFG_WIDTH-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ design/button_press_classifier.sv @@
// Button press classifier: each request word is one poll (millisecond time plus the raw
// levels of two active-low buttons and an active-high touch input) and yields exactly
// one response word with an event code (none, button short/long, touch). A poll is
// captured in an input register and classified, once the response register is free, by a
// 32-bit subtract and compare per input into the response register, so the block takes
// one word per clock while responses are not stalled; throughput is set only by the
// response handshake. Long press and touch guard times are the two CSRs (index 0 and 1,
// low 16 bits, reset 600 ms and 50 ms); write them only while no poll is in flight.
// Time differences wrap modulo 2^32. CSR writes are always ready.
module button_press_classifier import bpc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   bpc_req_if.sink       req,
   bpc_rsp_if.source     rsp,
   bpc_csr_if.sink       csr
);

   typedef struct packed {
      logic                  down;
      logic [TIME_WIDTH-1:0] start;
      logic                  long_done;
   } key_type;

   typedef struct packed {
      key_type        key;
      event_code_type code;
   } key_result_type;

   // configuration
   logic [CFG_WIDTH-1:0] long_press_ff;
   logic [CFG_WIDTH-1:0] touch_guard_ff;

   // input stage
   logic                  s1_valid_ff;
   logic [TIME_WIDTH-1:0] s1_now_ff;
   logic                  s1_b1_level_ff;
   logic                  s1_b2_level_ff;
   logic                  s1_touch_level_ff;

   // classifier state
   key_type               b1_ff, b1_in;
   key_type               b2_ff, b2_in;
   logic                  touch_prev_ff, touch_prev_in;
   logic [TIME_WIDTH-1:0] touch_time_ff, touch_time_in;

   // response stage
   logic           rsp_valid_ff;
   event_code_type rsp_code_ff, rsp_code_in;

   logic           advance;
   key_result_type b1_res, b2_res;
   logic [TIME_WIDTH-1:0] touch_diff;

   // One button: press edge, long hold, or release.
   function automatic key_result_type key_step(key_type k, logic pressed,
                                               logic [TIME_WIDTH-1:0] now,
                                               logic [CFG_WIDTH-1:0] long_ms,
                                               event_code_type ev_short,
                                               event_code_type ev_long);
      key_result_type        r;
      logic [TIME_WIDTH-1:0] held;
      held   = now - k.start;
      r.key  = k;
      r.code = EVT_NONE;
      if (pressed && !k.down) begin
         r.key.start     = now;
         r.key.long_done = 1'b0;
      end else if (pressed && k.down && !k.long_done &&
                   held > {{(TIME_WIDTH-CFG_WIDTH){1'b0}}, long_ms}) begin
         r.key.long_done = 1'b1;
         r.code          = ev_long;
      end else if (!pressed && k.down && !k.long_done) begin
         r.code = ev_short;
      end
      r.key.down = pressed;
      return r;
   endfunction

   // Move the held poll to the response register when that register is free.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || advance;
   assign csr.ready = 1'b1;

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.event_code = rsp_code_ff;

   assign touch_diff = s1_now_ff - touch_time_ff;

   always_comb begin
      b1_res = key_step(b1_ff, !s1_b1_level_ff, s1_now_ff, long_press_ff,
                        EVT_B1_SHORT, EVT_B1_LONG);
      b2_res = key_step(b2_ff, !s1_b2_level_ff, s1_now_ff, long_press_ff,
                        EVT_B2_SHORT, EVT_B2_LONG);

      b1_in         = b1_res.key;
      b2_in         = b2_ff;
      touch_prev_in = touch_prev_ff;
      touch_time_in = touch_time_ff;
      rsp_code_in   = b1_res.code;

      // Button 1 event ends the poll; button 2 event shields touch.
      if (b1_res.code == EVT_NONE) begin
         b2_in       = b2_res.key;
         rsp_code_in = b2_res.code;
         if (b2_res.code == EVT_NONE && s1_touch_level_ff != touch_prev_ff &&
             touch_diff > {{(TIME_WIDTH-CFG_WIDTH){1'b0}}, touch_guard_ff}) begin
            touch_prev_in = s1_touch_level_ff;
            touch_time_in = s1_now_ff;
            if (s1_touch_level_ff) begin
               rsp_code_in = EVT_TOUCH;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff  <= LONG_PRESS_RESET;
         touch_guard_ff <= TOUCH_GUARD_RESET;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         b1_ff          <= '0;
         b2_ff          <= '0;
         touch_prev_ff  <= 1'b0;
         touch_time_ff  <= '0;
      end else begin
         if (csr.valid) begin
            case (csr_index_type'(csr.index))
               CSR_LONG_PRESS:  long_press_ff  <= csr.data;
               CSR_TOUCH_GUARD: touch_guard_ff <= csr.data;
               default: ;
            endcase
         end

         if (req.valid && req.ready) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end

         if (advance) begin
            rsp_valid_ff  <= 1'b1;
            b1_ff         <= b1_in;
            b2_ff         <= b2_in;
            touch_prev_ff <= touch_prev_in;
            touch_time_ff <= touch_time_in;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: no reset.
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         s1_now_ff         <= req.now_ms;
         s1_b1_level_ff    <= req.button1_level;
         s1_b2_level_ff    <= req.button2_level;
         s1_touch_level_ff <= req.touch_level;
      end
      if (advance) begin
         rsp_code_ff <= rsp_code_in;
      end
   end

   // A long event for button 1 leaves its long flag set.
   assert property (@(posedge clock) disable iff (reset)
      (advance && rsp_code_in == EVT_B1_LONG) |=> b1_ff.long_done)
      else $error("button 1 long flag not set after long event");

   // A button 1 event leaves button 2 state untouched.
   assert property (@(posedge clock) disable iff (reset)
      (advance && (rsp_code_in == EVT_B1_SHORT || rsp_code_in == EVT_B1_LONG))
      |=> (b2_ff == $past(b2_ff)))
      else $error("button 2 state changed under a button 1 event");

   // A touch event records a high touch level.
   assert property (@(posedge clock) disable iff (reset)
      (advance && rsp_code_in == EVT_TOUCH) |=> touch_prev_ff)
      else $error("touch event without high touch level");

   // A word leaves the input stage only into a free response register.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |-> !advance)
      else $error("response overwritten while stalled");

endmodule
